>>> design/assert_macros.svh
// assertion macros for the sorter, included by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> design/msort_pkg.sv
`timescale 1ns / 1ps
package msort_pkg;

	// word width of the sorted values
	localparam int WORD_W = 32;
	// default number of store cells
	localparam int CAPACITY_DEF = 64;

	// commands from controller to datapath
	typedef struct packed {
		logic insert;
		logic drain;
	} msort_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
		logic last_one;
	} msort_sts_t;

endpackage

>>> design/msort_ctrl.sv
`timescale 1ns / 1ps
module msort_ctrl
	import msort_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	input  logic       last,
	output logic       src_stall,
	output msort_cmd_t cmd,
	input  msort_sts_t sts
);

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// input is held off while the run drains
	assign src_stall  = (state_q == ST_DRAIN);
	assign accept     = src_valid && !src_stall;
	assign cmd.insert = accept;
	assign cmd.drain  = (state_q == ST_DRAIN) && sts.out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cmd.drain && sts.last_one) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/msort_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msort_dpath
	import msort_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [WORD_W-1:0] value,
	input  msort_cmd_t               cmd,
	output msort_sts_t               sts,
	output logic signed [WORD_W-1:0] sorted_value,
	output logic                     final_res,
	output logic                     dropped,
	output logic                     dst_valid,
	input  logic                     dst_stall
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [WORD_W-1:0] cell_q [CAPACITY];
	logic signed [WORD_W-1:0] cell_d [CAPACITY];
	logic [CAPACITY-1:0]      gt;
	logic [CW-1:0]            fill_q;
	logic                     ovf_q;
	logic                     full;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] out_word_q;
	logic                     out_final_q;
	logic                     out_drop_q;

	assign full         = (fill_q == CW'(CAPACITY));
	assign sts.out_free = !out_valid_q || !dst_stall;
	assign sts.last_one = (fill_q == CW'(1));

	// per-cell compare: occupied cell's held word is greater than the new one
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (fill_q > CW'(i)) && (value < cell_q[i]);
		end
	end

	// per-cell next word: insert with shift up, or drain with shift down
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_d[i] = cell_q[i];
			if (cmd.insert && !full) begin
				if (gt[i] || fill_q == CW'(i)) begin
					if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
						cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
					end else begin
						cell_d[i] = value;
					end
				end
			end else if (cmd.drain && i < CAPACITY - 1) begin
				cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	// cell row
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_q[i] <= cell_d[i];
		end
	end

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.insert) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				fill_q <= fill_q + CW'(1);
			end
		end else if (cmd.drain) begin
			fill_q <= fill_q - CW'(1);
			if (sts.last_one) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.drain) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			out_word_q  <= cell_q[0];
			out_final_q <= sts.last_one;
			out_drop_q  <= ovf_q;
		end
	end

	assign dst_valid    = out_valid_q;
	assign sorted_value = out_word_q;
	assign final_res    = out_final_q;
	assign dropped      = out_drop_q;

	`ASSERT_CLK(a_fill_range, fill_q <= CW'(CAPACITY), "fill count above capacity")
	`ASSERT_NEVER(a_drain_empty, cmd.drain && fill_q == '0, "drain from empty store")
	`ASSERT_NEVER(a_cmd_overlap, cmd.insert && cmd.drain, "insert and drain together")
	`ASSERT_CLK(a_drain_shows, cmd.drain |=> dst_valid && dropped == $past(ovf_q), "drained word lost")

endmodule

>>> design/merge_insertion_sorter.sv
`timescale 1ns / 1ps
// sorts a run of signed 32-bit words, emitted in ascending order at run end
// source channel: value, last with src_valid / src_stall; one word is taken
//   per cycle while loading, each placed at once into a row of compare and
//   shift cells
// result channel: sorted_value, final_res, dropped with dst_valid / dst_stall
// after the word marked last is taken, src_stall rises and the cells shift
//   out toward the output register, one word per cycle while not stalled;
//   the state register first switches to drain, then the output register
//   takes the first result and each further one in turn
// final_res marks the last result; dropped is set on every result of a run
//   that had more than CAPACITY words, the extra words being discarded
// a dst_stall holds the output register and pauses the drain; the source
//   is free again once the final word is in the output register
// reset (arst_n low) empties the store and clears the output valid
module merge_insertion_sorter
	import msort_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     last,
	input  logic                     src_valid,
	output logic                     src_stall,
	output logic signed [WORD_W-1:0] sorted_value,
	output logic                     final_res,
	output logic                     dropped,
	output logic                     dst_valid,
	input  logic                     dst_stall
);

	msort_cmd_t cmd;
	msort_sts_t sts;

	// run controller
	msort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.last      (last),
		.src_stall (src_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// cell row and output register
	msort_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.sts          (sts),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.dropped      (dropped),
		.dst_valid    (dst_valid),
		.dst_stall    (dst_stall)
	);

endmodule

>>> test/tb_merge_insertion_sorter.sv
`timescale 1ns / 1ps
module tb_merge_insertion_sorter;
	import msort_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic signed [WORD_W-1:0] VMAX = 32'sh7fffffff;
	localparam logic signed [WORD_W-1:0] VMIN = 32'sh80000000;
	localparam int WORDS_PER_PHASE = 140;
	localparam int DRAIN_CYCLES = 150;

	// one sorted word as it leaves the block
	typedef struct packed {
		logic signed [WORD_W-1:0] val;
		logic                     fin;
		logic                     drop;
	} sort_res_t;

	// one directed word, with its result typed in where it is obvious
	typedef struct packed {
		logic signed [WORD_W-1:0] v;
		logic                     l;
		logic                     typed;
		logic signed [WORD_W-1:0] ev;
		logic                     ef;
		logic                     ed;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic signed [WORD_W-1:0] value = '0;
	logic                     last = 1'b0;
	logic                     src_valid = 1'b0;
	logic                     src_stall;
	logic signed [WORD_W-1:0] sorted_value;
	logic                     final_res;
	logic                     dropped;
	logic                     dst_valid;
	logic                     dst_stall = 1'b0;

	// predictor state: the run held so far, in ascending order
	logic signed [WORD_W-1:0] run_store[$];
	logic                     run_overflow = 1'b0;
	// sorted words still to come out of the block
	sort_res_t                sorted_q[$];

	int src_idle_pct = 25;
	int dst_idle_pct = 55;
	int n_fail = 0;
	int n_words = 0;
	int n_runs = 0;
	int n_overflow_runs = 0;
	int n_checked = 0;
	sort_res_t want_res;

	// singles with extremes, then short runs covering order, ties and duplicates
	dir_row_t dir_tab [0:20] = '{
		'{VMAX,    1'b1, 1'b1, VMAX,    1'b1, 1'b0},
		'{VMIN,    1'b1, 1'b1, VMIN,    1'b1, 1'b0},
		'{32'sd0,  1'b1, 1'b1, 32'sd0,  1'b1, 1'b0},
		'{-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b1, 1'b0},
		'{32'sd5,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{-32'sd1, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{VMAX,    1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{VMIN,    1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd5,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd0,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd5,  1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd3,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd2,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd1,  1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd1,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd2,  1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd7,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd7,  1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{32'sd7,  1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{VMIN,    1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
		'{VMIN,    1'b1, 1'b0, 32'sd0,  1'b0, 1'b0}
	};

	merge_insertion_sorter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.last         (last),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.dropped      (dropped),
		.dst_valid    (dst_valid),
		.dst_stall    (dst_stall)
	);

	always #1 clk = ~clk;

	// insert one word into the predicted run; on the last word emit the run if emit is set
	function automatic void store_and_flush(input logic signed [WORD_W-1:0] v, input logic l,
			input bit emit);
		int pos;
		sort_res_t r;
		if (run_store.size() >= CAP) begin
			run_overflow = 1'b1;
		end else begin
			pos = run_store.size();
			// equal words go after the ones already held
			while (pos > 0 && v < run_store[pos-1])
				pos--;
			run_store.insert(pos, v);
		end
		if (l) begin
			n_runs++;
			if (run_overflow)
				n_overflow_runs++;
			if (emit) begin
				foreach (run_store[k]) begin
					r.val  = run_store[k];
					r.fin  = (k == run_store.size() - 1);
					r.drop = run_overflow;
					sorted_q = {sorted_q, r};
				end
			end
			run_store.delete();
			run_overflow = 1'b0;
		end
	endfunction

	// present one word, hold it until taken, then predict its results
	task automatic send_word(input logic signed [WORD_W-1:0] v, input logic l, input bit typed,
			input sort_res_t typed_res);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		value     <= v;
		last      <= l;
		@(posedge clk);
		while (src_stall !== 1'b0)
			@(posedge clk);
		n_words++;
		store_and_flush(v, l, !typed);
		if (typed)
			sorted_q = {sorted_q, typed_res};
	endtask

	// hold off the source until every predicted word has come out
	task automatic wait_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
	endtask

	// random word: mostly full range, some small for ties, some extremes or repeats
	function automatic logic signed [WORD_W-1:0] pick_value(input logic signed [WORD_W-1:0] prev);
		logic signed [WORD_W-1:0] v;
		case ($urandom_range(9))
			6, 7: v = int'($urandom_range(16)) - 8;
			8: begin
				case ($urandom_range(3))
					0: v = VMIN;
					1: v = VMAX;
					2: v = '0;
					default: v = -32'sd1;
				endcase
			end
			9: v = prev;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// random run length: mostly short, some near or past capacity
	function automatic int pick_run_len();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return $urandom_range(CAP + 6, CAP + 1);
		else if (r < 14)
			return $urandom_range(CAP, CAP - 8);
		return $urandom_range(12, 1);
	endfunction

	task automatic send_run(input int len);
		logic signed [WORD_W-1:0] prev;
		logic signed [WORD_W-1:0] v;
		prev = $urandom;
		for (int i = 0; i < len; i++) begin
			v = pick_value(prev);
			send_word(v, i == len - 1, 1'b0, '0);
			prev = v;
		end
	endtask

	// result side: check each taken word, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall <= 1'b0;
		end else begin
			if (dst_valid && !dst_stall) begin
				n_checked++;
				if (sorted_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected word, expected none, got value %0d final %0b dropped %0b",
						$time, sorted_value, final_res, dropped);
				end else begin
					want_res = sorted_q.pop_front();
					if (sorted_value !== want_res.val) begin
						n_fail++;
						$display("%0t: sorted_value expected %0d got %0d",
							$time, want_res.val, sorted_value);
					end
					if (final_res !== want_res.fin) begin
						n_fail++;
						$display("%0t: final_res expected %0b got %0b",
							$time, want_res.fin, final_res);
					end
					if (dropped !== want_res.drop) begin
						n_fail++;
						$display("%0t: dropped expected %0b got %0b",
							$time, want_res.drop, dropped);
					end
				end
			end
			dst_stall <= ($urandom_range(99) < dst_idle_pct);
		end
	end

	// stimulus and end of run
	initial begin
		int phase_words;
		int len;
		sort_res_t tr;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			tr.val  = dir_tab[i].ev;
			tr.fin  = dir_tab[i].ef;
			tr.drop = dir_tab[i].ed;
			send_word(dir_tab[i].v, dir_tab[i].l, dir_tab[i].typed, tr);
		end
		wait_drained();

		// random runs in three idling phases
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin src_idle_pct = 25; dst_idle_pct = 55; end
				1: begin src_idle_pct = 55; dst_idle_pct = 25; end
				default: begin src_idle_pct = 0; dst_idle_pct = 0; end
			endcase
			phase_words = 0;
			while (phase_words < WORDS_PER_PHASE) begin
				// a full store in the first phase, an overflow in the second
				if (phase_words == 0 && p == 0)
					len = CAP;
				else if (phase_words == 0 && p == 1)
					len = CAP + 2;
				else
					len = pick_run_len();
				send_run(len);
				phase_words += len;
			end
			wait_drained();
		end

		// let any stray word show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d words in %0d runs, %0d of them past capacity",
			n_words, n_runs, n_overflow_runs);
		$display("checked %0d sorted words under mixed and absent backpressure", n_checked);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("timeout with %0d sorted words outstanding", sorted_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> merge_insertion_sorter.f
+incdir+design
design/msort_pkg.sv
design/msort_ctrl.sv
design/msort_dpath.sv
design/merge_insertion_sorter.sv
test/tb_merge_insertion_sorter.sv
